@@ hdl/stereo_long_fir_convolver_unit_assert.svh @@
// Assertion macros used by the convolver's checker file.
// Depends on nothing; included by the file that holds the concurrent assertions.
`ifndef STEREO_LONG_FIR_CONVOLVER_UNIT_ASSERT_SVH
`define STEREO_LONG_FIR_CONVOLVER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define SLFC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define SLFC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/slfc_pkg.sv @@
// Shared types and constants of the stereo long FIR convolver.
// Depends on nothing; imported by every module of the block but slfc_ram.
`default_nettype none

package slfc_pkg;

   localparam int unsigned FUNC_W       = 2;
   localparam int unsigned SAMPLE_W     = 24;
   localparam int unsigned COEF_W       = 24;
   localparam int unsigned COEF_INDEX_W = 12;
   localparam int unsigned CH_COUNT_W   = 2;
   localparam int unsigned TAP_COUNT_W  = 13;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 13;
   localparam int unsigned PROD_W       = SAMPLE_W + COEF_W;
   localparam int unsigned ACC_W        = 64;
   localparam int unsigned FRAC_BITS    = 23;

   // Item function codes.
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_COEF   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_COUNT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYPASS        = 2'd2;

   // Saturation limits of an output sample.
   localparam logic signed [SAMPLE_W-1:0] SAT_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAT_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Sequencer to multiply-accumulate datapath.
   typedef struct packed {
      logic issue;      // memory reads for one tap go out this cycle
      logic hist_zero;  // the history entry being read was never written
      logic acc_clear;  // start of a new sum
   } mac_ctl_type;

   // Sequencer to result register.
   typedef struct packed {
      logic load;  // load the result register this cycle
      logic pass;  // result is the bypassed sample
   } rsp_ctl_type;

   // Rounded and saturated sums of both channels.
   typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic                clip_l;
      logic                clip_r;
   } mac_res_type;

endpackage

`default_nettype wire

@@ hdl/stereo_long_fir_convolver_unit.sv @@
// Top level of the stereo long FIR convolver: configuration registers, memories, sequencer,
// MAC datapath and result register. Depends on slfc_pkg, slfc_ctrl, slfc_ram and slfc_mac.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+------------------------------------------------
//   req     | req_valid / req_ready  | func, sample, coef_channel, coef_index, coef_value
//   rsp     | rsp_valid / rsp_ready  | left, right, clipped
//   csr     | csr_valid / csr_ready  | csr_index, csr_wdata
//
// A filtered sample walks taps entries, taps being the clamped tap count; the walk
// reads one history entry and one coefficient pair per cycle, and both channels share it.
// A bypassed sample goes straight to the output register; a coefficient write is read-merge-write.
// Reset and history clear are immediate: a fill marker makes unwritten history read as zero.
// A result waits in the output register while the next item is taken; a result
// finishing while that register is still full holds the sequencer until it drains.
`default_nettype none

module stereo_long_fir_convolver_unit #(
   parameter int unsigned MAX_TAPS = 4096,
   localparam int unsigned PTR_W = $clog2(MAX_TAPS)
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [slfc_pkg::FUNC_W-1:0]              req_func,
   input  logic signed [slfc_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                                    req_coef_channel,
   input  logic [slfc_pkg::COEF_INDEX_W-1:0]        req_coef_index,
   input  logic signed [slfc_pkg::COEF_W-1:0]       req_coef_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [slfc_pkg::SAMPLE_W-1:0]     rsp_left,
   output logic signed [slfc_pkg::SAMPLE_W-1:0]     rsp_right,
   output logic                                    rsp_clipped,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [slfc_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [slfc_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   import slfc_pkg::*;

   logic [CH_COUNT_W-1:0]  channel_count_ff, channel_count_in;
   logic [TAP_COUNT_W-1:0] tap_count_ff, tap_count_in;
   logic                   bypass_ff, bypass_in;

   logic [SAMPLE_W-1:0] sample_ff;
   logic [COEF_W-1:0]   coef_value_ff;
   logic                coef_channel_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_left_ff, rsp_left_in;
   logic [SAMPLE_W-1:0] rsp_right_ff, rsp_right_in;
   logic                rsp_clipped_ff, rsp_clipped_in;

   logic                  req_accept;
   logic                  rsp_free;
   logic                  two_ch;
   logic                  hist_we, coef_we, mac_busy;
   logic [PTR_W-1:0]      hist_waddr, hist_raddr, coef_waddr, coef_raddr;
   logic [SAMPLE_W-1:0]   hist_rdata;
   logic [2*COEF_W-1:0]   coef_rdata, coef_wdata;
   mac_ctl_type           mac_ctl;
   rsp_ctl_type           rsp_ctl;
   mac_res_type           mac_res;

   assign req_accept = req_valid & req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = ~rsp_valid_ff | rsp_ready;
   // Channel counts of two and three both mean stereo.
   assign two_ch     = channel_count_ff[1];

   always_comb begin
      channel_count_in = channel_count_ff;
      tap_count_in     = tap_count_ff;
      bypass_in        = bypass_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT: channel_count_in = csr_wdata[CH_COUNT_W-1:0];
            CSR_TAP_COUNT:     tap_count_in     = csr_wdata[TAP_COUNT_W-1:0];
            CSR_BYPASS:        bypass_in        = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= CH_COUNT_W'(1);
         tap_count_ff     <= TAP_COUNT_W'(1);
         bypass_ff        <= 1'b1;
      end else begin
         channel_count_ff <= channel_count_in;
         tap_count_ff     <= tap_count_in;
         bypass_ff        <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff       <= req_sample;
         coef_value_ff   <= req_coef_value;
         coef_channel_ff <= req_coef_channel;
      end
   end

   slfc_ctrl #(
      .MAX_TAPS(MAX_TAPS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_coef_index(req_coef_index),
      .bypass        (bypass_ff),
      .tap_count     (tap_count_ff),
      .mac_busy      (mac_busy),
      .rsp_free      (rsp_free),
      .hist_we       (hist_we),
      .hist_waddr    (hist_waddr),
      .hist_raddr    (hist_raddr),
      .coef_we       (coef_we),
      .coef_waddr    (coef_waddr),
      .coef_raddr    (coef_raddr),
      .mac_ctl       (mac_ctl),
      .rsp_ctl       (rsp_ctl)
   );

   slfc_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(MAX_TAPS)
   ) u_hist_ram (
      .clock(clock),
      .we   (hist_we),
      .waddr(hist_waddr),
      .wdata(req_sample),
      .raddr(hist_raddr),
      .rdata(hist_rdata)
   );

   // Each entry holds both channels' taps; a write merges into the half it targets.
   assign coef_wdata = coef_channel_ff ? {coef_value_ff, coef_rdata[COEF_W-1:0]}
                                       : {coef_rdata[2*COEF_W-1:COEF_W], coef_value_ff};

   slfc_ram #(
      .WIDTH(2*COEF_W),
      .DEPTH(MAX_TAPS)
   ) u_coef_ram (
      .clock(clock),
      .we   (coef_we),
      .waddr(coef_waddr),
      .wdata(coef_wdata),
      .raddr(coef_raddr),
      .rdata(coef_rdata)
   );

   slfc_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .mac_ctl   (mac_ctl),
      .hist_rdata(hist_rdata),
      .coef_rdata(coef_rdata),
      .mac_busy  (mac_busy),
      .mac_res   (mac_res)
   );

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_left_in    = rsp_left_ff;
      rsp_right_in   = rsp_right_ff;
      rsp_clipped_in = rsp_clipped_ff;
      if (rsp_ctl.load) begin
         rsp_valid_in = 1'b1;
         if (rsp_ctl.pass) begin
            rsp_left_in    = sample_ff;
            rsp_right_in   = sample_ff;
            rsp_clipped_in = 1'b0;
         end else begin
            rsp_left_in    = mac_res.left;
            rsp_right_in   = two_ch ? mac_res.right : mac_res.left;
            rsp_clipped_in = mac_res.clip_l | (two_ch & mac_res.clip_r);
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_left_ff    <= rsp_left_in;
      rsp_right_ff   <= rsp_right_in;
      rsp_clipped_ff <= rsp_clipped_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_left    = rsp_left_ff;
   assign rsp_right   = rsp_right_ff;
   assign rsp_clipped = rsp_clipped_ff;

endmodule

`default_nettype wire

@@ hdl/slfc_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing; holds the history and the coefficient store.
`default_nettype none

module slfc_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 4096,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hdl/slfc_mac.sv @@
// Two-channel multiply-accumulate pipeline with rounding and saturation.
// Depends on slfc_pkg; fed by the memory read data and the sequencer.
`default_nettype none

module slfc_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  slfc_pkg::mac_ctl_type         mac_ctl,
   input  logic [slfc_pkg::SAMPLE_W-1:0] hist_rdata,
   input  logic [2*slfc_pkg::COEF_W-1:0] coef_rdata,
   output logic                          mac_busy,
   output slfc_pkg::mac_res_type         mac_res
);

   import slfc_pkg::*;

   localparam logic signed [ACC_W-1:0] ROUND_HALF =
      {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

   logic                     b_vld_ff, b_hzero_ff, c_vld_ff;
   logic signed [SAMPLE_W-1:0] hist_s;
   logic signed [COEF_W-1:0]   coef_l_s, coef_r_s;
   logic signed [PROD_W-1:0]   prod_l_ff, prod_r_ff, prod_l_in, prod_r_in;
   logic signed [ACC_W-1:0]    acc_l_ff, acc_r_ff, acc_l_in, acc_r_in;
   logic [SAMPLE_W:0]          sat_l, sat_r;

   // Returns {clip, sample}: add one half, floor, then saturate.
   function automatic logic [SAMPLE_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] biased;
      logic signed [ACC_W-1:0] shifted;
      biased  = acc + ROUND_HALF;
      shifted = biased >>> FRAC_BITS;
      if (shifted > ACC_W'(SAT_HI)) begin
         round_sat = {1'b1, SAT_HI};
      end else if (shifted < ACC_W'(SAT_LO)) begin
         round_sat = {1'b1, SAT_LO};
      end else begin
         round_sat = {1'b0, shifted[SAMPLE_W-1:0]};
      end
   endfunction

   always_comb begin
      hist_s   = b_hzero_ff ? '0 : $signed(hist_rdata);
      coef_l_s = $signed(coef_rdata[COEF_W-1:0]);
      coef_r_s = $signed(coef_rdata[2*COEF_W-1:COEF_W]);
      prod_l_in = coef_l_s * hist_s;
      prod_r_in = coef_r_s * hist_s;

      acc_l_in = acc_l_ff;
      acc_r_in = acc_r_ff;
      if (mac_ctl.acc_clear) begin
         acc_l_in = '0;
         acc_r_in = '0;
      end else if (c_vld_ff) begin
         acc_l_in = acc_l_ff + ACC_W'(prod_l_ff);
         acc_r_in = acc_r_ff + ACC_W'(prod_r_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= mac_ctl.issue;
         c_vld_ff <= b_vld_ff;
      end
      b_hzero_ff <= mac_ctl.hist_zero;
      prod_l_ff  <= prod_l_in;
      prod_r_ff  <= prod_r_in;
      acc_l_ff   <= acc_l_in;
      acc_r_ff   <= acc_r_in;
   end

   assign sat_l = round_sat(acc_l_ff);
   assign sat_r = round_sat(acc_r_ff);

   assign mac_busy       = b_vld_ff | c_vld_ff;
   assign mac_res.left   = sat_l[SAMPLE_W-1:0];
   assign mac_res.right  = sat_r[SAMPLE_W-1:0];
   assign mac_res.clip_l = sat_l[SAMPLE_W];
   assign mac_res.clip_r = sat_r[SAMPLE_W];

endmodule

`default_nettype wire

@@ hdl/slfc_ctrl.sv @@
// Sequencer: item decode, tap walk over the history and coefficient memories,
// history pointer and fill marker. Depends on slfc_pkg.
`default_nettype none

module slfc_ctrl #(
   parameter int unsigned MAX_TAPS = 4096,
   localparam int unsigned PTR_W = $clog2(MAX_TAPS)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [slfc_pkg::FUNC_W-1:0]       req_func,
   input  logic [slfc_pkg::COEF_INDEX_W-1:0] req_coef_index,
   input  logic                             bypass,
   input  logic [slfc_pkg::TAP_COUNT_W-1:0]  tap_count,
   input  logic                             mac_busy,
   input  logic                             rsp_free,
   output logic                             hist_we,
   output logic [PTR_W-1:0]                 hist_waddr,
   output logic [PTR_W-1:0]                 hist_raddr,
   output logic                             coef_we,
   output logic [PTR_W-1:0]                 coef_waddr,
   output logic [PTR_W-1:0]                 coef_raddr,
   output slfc_pkg::mac_ctl_type            mac_ctl,
   output slfc_pkg::rsp_ctl_type            rsp_ctl
);

   import slfc_pkg::*;

   localparam int unsigned CMP_W = (PTR_W + 1 > TAP_COUNT_W) ? PTR_W + 1 : TAP_COUNT_W;
   localparam int unsigned IDX_W =
      ((COEF_INDEX_W > PTR_W) ? COEF_INDEX_W : PTR_W) + 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_TAPS - 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MAC   = 5'b00010,
      S_DRAIN = 5'b00100,
      S_EMIT  = 5'b01000,
      S_CWR   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic             full_ff, full_in;
   logic [PTR_W-1:0] k_ff, k_in;
   logic [PTR_W-1:0] rd_idx_ff, rd_idx_in;
   logic             wrapped_ff, wrapped_in;
   logic [PTR_W-1:0] last_k_ff, last_k_in;
   logic [PTR_W-1:0] coef_addr_ff, coef_addr_in;
   logic             pass_ff, pass_in;
   logic             accept;
   logic [CMP_W-1:0] tc_ext, taps_ext;
   logic [IDX_W-1:0] idx_ext;
   logic             idx_ok;

   always_comb begin
      tc_ext = CMP_W'(tap_count);
      if (tc_ext == '0) begin
         taps_ext = CMP_W'(1);
      end else if (tc_ext > CMP_W'(MAX_TAPS)) begin
         taps_ext = CMP_W'(MAX_TAPS);
      end else begin
         taps_ext = tc_ext;
      end
      idx_ext = IDX_W'(req_coef_index);
      idx_ok  = idx_ext < IDX_W'(MAX_TAPS);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      full_in      = full_ff;
      k_in         = k_ff;
      rd_idx_in    = rd_idx_ff;
      wrapped_in   = wrapped_ff;
      last_k_in    = last_k_ff;
      coef_addr_in = coef_addr_ff;
      pass_in      = pass_ff;
      hist_we      = 1'b0;
      coef_we      = 1'b0;
      coef_raddr   = k_ff;
      mac_ctl      = '0;
      rsp_ctl      = '0;

      unique case (state_ff)
         S_IDLE: begin
            coef_raddr = PTR_W'(idx_ext);
            if (accept) begin
               unique case (req_func)
                  FUNC_SAMPLE: begin
                     if (bypass) begin
                        pass_in  = 1'b1;
                        state_in = S_EMIT;
                     end else begin
                        // The new sample lands at the pointer before the walk starts.
                        hist_we           = 1'b1;
                        pass_in           = 1'b0;
                        k_in              = '0;
                        rd_idx_in         = ptr_ff;
                        wrapped_in        = 1'b0;
                        last_k_in         = PTR_W'(taps_ext - CMP_W'(1));
                        mac_ctl.acc_clear = 1'b1;
                        state_in          = S_MAC;
                     end
                  end
                  FUNC_COEF: begin
                     if (idx_ok) begin
                        coef_addr_in = PTR_W'(idx_ext);
                        state_in     = S_CWR;
                     end
                  end
                  FUNC_CLEAR: begin
                     ptr_in  = '0;
                     full_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MAC: begin
            // Entries behind the pointer are live only once the history has filled.
            mac_ctl.issue     = 1'b1;
            mac_ctl.hist_zero = wrapped_ff & ~full_ff;
            if (k_ff == last_k_ff) begin
               ptr_in   = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);
               full_in  = full_ff | (ptr_ff == PTR_LAST);
               state_in = S_DRAIN;
            end else begin
               k_in       = k_ff + PTR_W'(1);
               rd_idx_in  = (rd_idx_ff == '0) ? PTR_LAST : rd_idx_ff - PTR_W'(1);
               wrapped_in = wrapped_ff | (rd_idx_ff == '0);
            end
         end
         S_DRAIN: begin
            if (!mac_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_ctl.pass = pass_ff;
            if (rsp_free) begin
               rsp_ctl.load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_CWR: begin
            coef_we  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ptr_ff   <= '0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         full_ff  <= full_in;
      end
      k_ff         <= k_in;
      rd_idx_ff    <= rd_idx_in;
      wrapped_ff   <= wrapped_in;
      last_k_ff    <= last_k_in;
      coef_addr_ff <= coef_addr_in;
      pass_ff      <= pass_in;
   end

   assign hist_waddr = ptr_ff;
   assign hist_raddr = rd_idx_ff;
   assign coef_waddr = coef_addr_ff;

endmodule

`default_nettype wire

@@ hdl/slfc_checker.sv @@
// Port-level checker for the stereo long FIR convolver, bound to the top level.
// Depends on slfc_pkg and the assertion macro header.
`default_nettype none

`include "stereo_long_fir_convolver_unit_assert.svh"

module slfc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [slfc_pkg::SAMPLE_W-1:0] rsp_left,
   input logic signed [slfc_pkg::SAMPLE_W-1:0] rsp_right,
   input logic                                rsp_clipped
);

   import slfc_pkg::*;

   logic                  clip_shown;
   logic                  at_rail;
   logic                  rsp_stall;
   logic [2*SAMPLE_W:0]   rsp_word;

   assign clip_shown = rsp_valid & rsp_clipped;
   assign at_rail    = (rsp_left == SAT_HI) || (rsp_left == SAT_LO) ||
                       (rsp_right == SAT_HI) || (rsp_right == SAT_LO);
   assign rsp_stall  = rsp_valid & ~rsp_ready;
   assign rsp_word   = {rsp_left, rsp_right, rsp_clipped};

   // A result may only claim clipping when one of its channels sits at a rail.
   `SLFC_ASSERT(a_clip_at_rail, clock, reset, clip_shown |-> at_rail, "clip flag off the rails")

   `SLFC_ASSERT_ALWAYS(a_reset_no_rsp, clock, reset |=> !rsp_valid, "result right after reset")

   `SLFC_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid, "result dropped while stalled")

   `SLFC_ASSERT(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_word), "stalled result changed")

endmodule

bind stereo_long_fir_convolver_unit slfc_checker u_slfc_checker (.*);

`default_nettype wire
